### hdl/nst_pkg.sv
// shared types, codes and constants of the note sequencer
package nst_pkg;

   // default sizes
   localparam int NOTE_SLOTS_DEF    = 64;
   localparam int TONE_CLOCK_HZ_DEF = 62500;

   // field widths
   localparam int FUNC_W   = 3;
   localparam int SLOT_W   = 6;
   localparam int FREQ_W   = 16;
   localparam int MS_W     = 16;
   localparam int TOP_W    = 8;
   localparam int VOL_W    = 7;
   localparam int NIDX_W   = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // wide enough for any slot index up to 1024 entries
   localparam int WIDE_IDX_W = 11;

   // item function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PLAY     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_VOL_UP   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_VOL_DOWN = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SONG_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_MS  = 2'd1;

   // reset values and volume handling
   localparam logic [MS_W-1:0]  SILENCE_MS_RST = 16'd100;
   localparam logic [VOL_W-1:0] VOL_PLAY       = 7'd50;
   localparam logic [VOL_W-1:0] VOL_STEP       = 7'd10;
   localparam logic [VOL_W-1:0] VOL_UP_MAX     = 7'd80;
   localparam logic [VOL_W-1:0] VOL_DOWN_MIN   = 7'd10;
   localparam logic [TOP_W-1:0] TOP_SAT        = 8'hFF;

   // divide by 100 as multiply by reciprocal, exact for products below 2**15
   localparam int PROD_W     = TOP_W + VOL_W;
   localparam int RECIP_W    = 13;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int RECIP_SH   = 19;
   localparam int SCALED_W   = PROD_W + RECIP_W;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
      logic fetch;
      logic div_step;
      logic tone;
      logic mul;
      logic scale;
      logic out_load;
   } nst_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic note_start;
      logic div_last;
      logic out_free;
   } nst_stat_type;

endpackage

### hdl/nst_ifs.sv
// channel interfaces: note request, result and register write

interface nst_req_if;
   logic                       valid;
   logic                       ready;
   logic [nst_pkg::FUNC_W-1:0] func;
   logic [nst_pkg::SLOT_W-1:0] note_slot;
   logic [nst_pkg::FREQ_W-1:0] note_freq;
   logic [nst_pkg::MS_W-1:0]   note_ms;
   modport source (output valid, func, note_slot, note_freq, note_ms, input ready);
   modport sink   (input valid, func, note_slot, note_freq, note_ms, output ready);
endinterface

interface nst_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       tone_on;
   logic [nst_pkg::TOP_W-1:0]  tone_top;
   logic [nst_pkg::TOP_W-1:0]  duty_compare;
   logic [nst_pkg::VOL_W-1:0]  volume;
   logic [nst_pkg::NIDX_W-1:0] next_note;
   logic                       song_done;
   modport source (output valid, tone_on, tone_top, duty_compare, volume, next_note,
                   song_done, input ready);
   modport sink   (input valid, tone_on, tone_top, duty_compare, volume, next_note,
                   song_done, output ready);
endinterface

interface nst_csr_if;
   logic                           valid;
   logic                           ready;
   logic [nst_pkg::CSR_IDX_W-1:0]  index;
   logic [nst_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hdl/note_sequencer_tone_pwm_unit.sv
// top level of the note sequencer with tone divider and pwm volume
//
//   channel   dir   transfer moves
//   req_chan  in    func, note_slot, note_freq, note_ms
//   rsp_chan  out   tone_on, tone_top, duty_compare, volume, next_note, song_done
//   csr_chan  in    register index and write data (0 song_length, 1 silence_ms)
//
// one item at a time: an item goes through exec, mul, scale and out to a valid result,
// and a tick that starts a note also through fetch, div and tone, one divider step per
// bit of TONE_CLOCK_HZ (16 at 62500); no new item is taken before the last leaves out.
// the result register holds a finished result while the next item is taken;
// a stalled result only delays the item after it.
// synchronous active-high reset; the note table has no reset and is valid once written.
module note_sequencer_tone_pwm_unit #(
   parameter int NOTE_SLOTS    = nst_pkg::NOTE_SLOTS_DEF,
   parameter int TONE_CLOCK_HZ = nst_pkg::TONE_CLOCK_HZ_DEF
) (
   input logic       clock,
   input logic       reset,
   nst_req_if.sink   req_chan,
   nst_rsp_if.source rsp_chan,
   nst_csr_if.sink   csr_chan
);
   import nst_pkg::*;

   nst_cmd_type  cmd;
   nst_stat_type stat;

   // controller
   nst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   nst_dpath #(
      .NOTE_SLOTS    (NOTE_SLOTS),
      .TONE_CLOCK_HZ (TONE_CLOCK_HZ)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

### hdl/nst_ctrl.sv
// sequencing state machine of the note sequencer
module nst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  nst_pkg::nst_stat_type stat,
   output nst_pkg::nst_cmd_type  cmd
);
   import nst_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_EXEC  = 8'b0000_0010,
      ST_FETCH = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_TONE  = 8'b0001_0000,
      ST_MUL   = 8'b0010_0000,
      ST_SCALE = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // one item at a time, taken only when idle
   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.note_start ? ST_FETCH : ST_MUL;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_TONE;
         end
         ST_TONE: begin
            cmd.tone = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### hdl/nst_dpath.sv
// note tables, timing counters, tone divider, duty scaling and result register
module nst_dpath #(
   parameter int NOTE_SLOTS    = nst_pkg::NOTE_SLOTS_DEF,
   parameter int TONE_CLOCK_HZ = nst_pkg::TONE_CLOCK_HZ_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   nst_req_if.sink              req_chan,
   nst_rsp_if.source            rsp_chan,
   nst_csr_if.sink              csr_chan,
   input  nst_pkg::nst_cmd_type cmd,
   output nst_pkg::nst_stat_type stat
);
   import nst_pkg::*;

   localparam int AW    = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
   localparam int DW    = $clog2(TONE_CLOCK_HZ + 1);
   localparam int CNT_W = $clog2(DW);
   localparam int ENT_W = FREQ_W + MS_W;

   // note table: frequency in the upper half, duration in the lower
   logic [ENT_W-1:0] note_mem [NOTE_SLOTS];
   logic [ENT_W-1:0] rd_ff;

   // latched item
   logic [FUNC_W-1:0] func_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [FREQ_W-1:0] wr_freq_ff;
   logic [MS_W-1:0]   wr_ms_ff;

   // sequencer state
   logic [MS_W-1:0]   ms_count_ff, ms_count_in;
   logic [MS_W-1:0]   delay_ff, delay_in;
   logic [NIDX_W-1:0] note_index_ff, note_index_in;
   logic              gap_done_ff, gap_done_in;
   logic [VOL_W-1:0]  vol_ff, vol_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic              tone_en_ff, tone_en_in;
   logic [NIDX_W-1:0] song_len_ff;
   logic [MS_W-1:0]   silence_ff;

   // divider
   logic [DW-1:0]     dvd_ff;
   logic [FREQ_W-1:0] rem_ff;
   logic [DW-1:0]     quo_ff;
   logic [FREQ_W-1:0] divisor_ff;
   logic              freq_ok_ff;
   logic [CNT_W-1:0]  cnt_ff;

   // duty scaling
   logic [PROD_W-1:0] prod_ff;
   logic [TOP_W-1:0]  duty_ff;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_tone_on_ff;
   logic [TOP_W-1:0]  rsp_top_ff;
   logic [TOP_W-1:0]  rsp_duty_ff;
   logic [VOL_W-1:0]  rsp_vol_ff;
   logic [NIDX_W-1:0] rsp_next_ff;
   logic              rsp_done_ff;

   logic [WIDE_IDX_W-1:0] wr_wide, rd_wide;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic                  wr_en;
   logic [MS_W-1:0]       ms_inc;
   logic                  fire;
   logic                  is_tick;
   logic                  in_range;
   logic [FREQ_W-1:0]     fetch_freq;
   logic [MS_W-1:0]       fetch_ms;
   logic [FREQ_W:0]       rem_sh;
   logic                  rem_ge;
   logic [TOP_W-1:0]      ticks_sat;
   logic [SCALED_W-1:0]   scaled;
   logic                  csr_wr;

   // addresses into the note table
   assign wr_wide = WIDE_IDX_W'(slot_ff);
   assign rd_wide = WIDE_IDX_W'(note_index_ff);
   assign wr_addr = wr_wide[AW-1:0];
   assign rd_addr = rd_wide[AW-1:0];
   assign wr_en   = cmd.exec && (func_ff == FUNC_WRITE) && (int'(slot_ff) < NOTE_SLOTS);

   // note table write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) note_mem[wr_addr] <= {wr_freq_ff, wr_ms_ff};
      rd_ff <= note_mem[rd_addr];
   end

   // input latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= req_chan.func;
         slot_ff    <= req_chan.note_slot;
         wr_freq_ff <= req_chan.note_freq;
         wr_ms_ff   <= req_chan.note_ms;
      end
   end

   // register writes
   assign csr_chan.ready = 1'b1;
   assign csr_wr         = csr_chan.valid;
   always_ff @(posedge clock) begin
      if (reset) begin
         song_len_ff <= '0;
         silence_ff  <= SILENCE_MS_RST;
      end else if (csr_wr) begin
         if (csr_chan.index == CSR_SONG_LENGTH) song_len_ff <= csr_chan.data[NIDX_W-1:0];
         if (csr_chan.index == CSR_SILENCE_MS)  silence_ff  <= csr_chan.data[MS_W-1:0];
      end
   end

   // millisecond tick decision
   assign is_tick = (func_ff == FUNC_TICK);
   assign ms_inc  = ms_count_ff + 1'b1;
   assign fire    = !(ms_inc < delay_ff);
   assign stat.note_start = is_tick && fire && gap_done_ff && (note_index_ff != song_len_ff);

   // fetched note, silent and zero length beyond the table
   assign in_range   = int'(note_index_ff) < NOTE_SLOTS;
   assign fetch_freq = in_range ? rd_ff[ENT_W-1:MS_W] : '0;
   assign fetch_ms   = in_range ? rd_ff[MS_W-1:0] : '0;

   // saturated quotient
   assign ticks_sat = (quo_ff > DW'(TOP_SAT)) ? TOP_SAT : quo_ff[TOP_W-1:0];

   // sequencer state update
   always_comb begin
      ms_count_in   = ms_count_ff;
      delay_in      = delay_ff;
      note_index_in = note_index_ff;
      gap_done_in   = gap_done_ff;
      vol_in        = vol_ff;
      top_in        = top_ff;
      tone_en_in    = tone_en_ff;
      if (cmd.exec) begin
         case (func_ff)
            FUNC_TICK: begin
               ms_count_in = fire ? '0 : ms_inc;
               if (fire && !stat.note_start) begin
                  gap_done_in = 1'b1;
                  tone_en_in  = 1'b0;
                  delay_in    = silence_ff;
               end
            end
            FUNC_PLAY: begin
               note_index_in = '0;
               vol_in        = VOL_PLAY;
            end
            FUNC_VOL_UP: begin
               if (vol_ff <= VOL_UP_MAX) vol_in = vol_ff + VOL_STEP;
            end
            FUNC_VOL_DOWN: begin
               if (vol_ff >= VOL_DOWN_MIN) vol_in = vol_ff - VOL_STEP;
            end
            default: ;
         endcase
      end
      if (cmd.fetch) begin
         gap_done_in   = 1'b0;
         delay_in      = fetch_ms;
         note_index_in = note_index_ff + 1'b1;
      end
      if (cmd.tone) begin
         if (freq_ok_ff && (ticks_sat != '0)) begin
            top_in     = ticks_sat - 1'b1;
            tone_en_in = 1'b1;
         end else begin
            tone_en_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_count_ff   <= '0;
         delay_ff      <= '0;
         note_index_ff <= '0;
         gap_done_ff   <= 1'b1;
         vol_ff        <= '0;
         top_ff        <= '0;
         tone_en_ff    <= 1'b0;
      end else begin
         ms_count_ff   <= ms_count_in;
         delay_ff      <= delay_in;
         note_index_ff <= note_index_in;
         gap_done_ff   <= gap_done_in;
         vol_ff        <= vol_in;
         top_ff        <= top_in;
         tone_en_ff    <= tone_en_in;
      end
   end

   // restoring divider, one quotient bit a cycle
   assign rem_sh = {rem_ff, dvd_ff[DW-1]};
   assign rem_ge = rem_sh >= {1'b0, divisor_ff};
   assign stat.div_last = (cnt_ff == CNT_W'(DW - 1));

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         dvd_ff     <= DW'(TONE_CLOCK_HZ);
         rem_ff     <= '0;
         quo_ff     <= '0;
         divisor_ff <= fetch_freq;
         freq_ok_ff <= (fetch_freq != '0);
         cnt_ff     <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= rem_ge ? FREQ_W'(rem_sh - {1'b0, divisor_ff}) : rem_sh[FREQ_W-1:0];
         quo_ff <= {quo_ff[DW-2:0], rem_ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // duty compare: top times volume, then divide by 100 via reciprocal
   assign scaled = SCALED_W'(prod_ff) * SCALED_W'(RECIP_100);
   always_ff @(posedge clock) begin
      if (cmd.mul)   prod_ff <= PROD_W'(top_ff) * PROD_W'(vol_ff);
      if (cmd.scale) duty_ff <= scaled[RECIP_SH +: TOP_W];
   end

   // result register, free once the last transfer has gone
   assign stat.out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_tone_on_ff <= tone_en_ff;
         rsp_top_ff     <= top_ff;
         rsp_duty_ff    <= duty_ff;
         rsp_vol_ff     <= vol_ff;
         rsp_next_ff    <= note_index_ff;
         rsp_done_ff    <= (note_index_ff == song_len_ff);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.tone_on      = rsp_tone_on_ff;
   assign rsp_chan.tone_top     = rsp_top_ff;
   assign rsp_chan.duty_compare = rsp_duty_ff;
   assign rsp_chan.volume       = rsp_vol_ff;
   assign rsp_chan.next_note    = rsp_next_ff;
   assign rsp_chan.song_done    = rsp_done_ff;

endmodule

### hdl/nst_checker.sv
// port checks of the note sequencer and their binding to the top level
module nst_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [nst_pkg::TOP_W-1:0]  rsp_tone_top,
   input logic [nst_pkg::TOP_W-1:0]  rsp_duty,
   input logic [nst_pkg::VOL_W-1:0]  rsp_volume
);
   import nst_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty) && $stable(rsp_tone_top))
      else $error("result changed while stalled");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while another is in work");

   // volume stays in range
   a_vol_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_volume <= 7'd90)
      else $error("volume out of range");

   // duty never exceeds the period top
   a_duty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty <= rsp_tone_top)
      else $error("duty compare above tone top");

endmodule

bind note_sequencer_tone_pwm_unit nst_checker u_nst_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_tone_top (rsp_chan.tone_top),
   .rsp_duty     (rsp_chan.duty_compare),
   .rsp_volume   (rsp_chan.volume)
);

### bench/testbench.sv
// testbench for the note sequencer: directed and random items checked against a predictor
`timescale 1ns / 100ps

// one request item and one result item as the bench sees them
typedef struct packed {
   logic [nst_pkg::FUNC_W-1:0] func;
   logic [nst_pkg::SLOT_W-1:0] slot;
   logic [nst_pkg::FREQ_W-1:0] freq;
   logic [nst_pkg::MS_W-1:0]   dur;
} note_req_type;

typedef struct packed {
   logic                       tone_on;
   logic [nst_pkg::TOP_W-1:0]  tone_top;
   logic [nst_pkg::TOP_W-1:0]  duty;
   logic [nst_pkg::VOL_W-1:0]  volume;
   logic [nst_pkg::NIDX_W-1:0] next_note;
   logic                       song_done;
} tone_rsp_type;

// tone sequencer predictor and store of expected results
class tone_scoreboard;
   localparam int SLOTS   = nst_pkg::NOTE_SLOTS_DEF;
   localparam int PERCENT = 100;

   logic [nst_pkg::FREQ_W-1:0] freq_tab [SLOTS];
   logic [nst_pkg::MS_W-1:0]   dur_tab [SLOTS];
   bit                         slot_written [SLOTS];
   logic [nst_pkg::MS_W-1:0]   ms_count, cur_delay, silence_ms;
   logic [nst_pkg::NIDX_W-1:0] note_idx, song_len;
   logic [nst_pkg::VOL_W-1:0]  vol;
   logic [nst_pkg::TOP_W-1:0]  top;
   bit                         gap_done, tone_en;
   tone_rsp_type               expected_q [$];
   int                         errors, compared, notes_started;

   function new();
      foreach (slot_written[i]) slot_written[i] = 1'b0;
      ms_count      = '0;
      cur_delay     = '0;
      note_idx      = '0;
      gap_done      = 1'b1;
      vol           = '0;
      top           = '0;
      tone_en       = 1'b0;
      song_len      = '0;
      silence_ms    = nst_pkg::SILENCE_MS_RST;
      errors        = 0;
      compared      = 0;
      notes_started = 0;
   endfunction

   function void write_reg(logic [nst_pkg::CSR_IDX_W-1:0] idx,
                           logic [nst_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         nst_pkg::CSR_SONG_LENGTH: song_len = data[nst_pkg::NIDX_W-1:0];
         nst_pkg::CSR_SILENCE_MS:  silence_ms = data;
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // slot that the next tick would fetch before it has ever been written, else -1
   function int unwritten_fetch();
      logic [nst_pkg::MS_W-1:0] next_ms;
      next_ms = ms_count + 1'b1;
      if (next_ms >= cur_delay && gap_done && note_idx != song_len && note_idx < SLOTS
          && !slot_written[note_idx])
         return note_idx;
      return -1;
   endfunction

   // divide the tone clock by the note frequency, saturating the period
   function void start_tone(logic [nst_pkg::FREQ_W-1:0] f);
      int unsigned ticks;
      ticks = 0;
      if (f != 0) begin
         ticks = nst_pkg::TONE_CLOCK_HZ_DEF / f;
         if (ticks > nst_pkg::TOP_SAT) ticks = nst_pkg::TOP_SAT;
      end
      if (ticks > 0) begin
         ticks   = ticks - 1;
         top     = ticks[nst_pkg::TOP_W-1:0];
         tone_en = 1'b1;
      end else begin
         tone_en = 1'b0;
      end
   endfunction

   // one millisecond: notes and silence gaps alternate
   function void ms_tick();
      logic [nst_pkg::FREQ_W-1:0] f;
      logic [nst_pkg::MS_W-1:0]   d;
      ms_count = ms_count + 1'b1;
      if (ms_count < cur_delay) return;
      ms_count = '0;
      if (gap_done && note_idx != song_len) begin
         f = '0;
         d = '0;
         // past the end of the table reads as a silent note of zero length
         if (note_idx < SLOTS) begin
            f = freq_tab[note_idx];
            d = dur_tab[note_idx];
         end
         start_tone(f);
         gap_done  = 1'b0;
         cur_delay = d;
         note_idx  = note_idx + 1'b1;
         notes_started++;
      end else begin
         gap_done  = 1'b1;
         tone_en   = 1'b0;
         cur_delay = silence_ms;
      end
   endfunction

   // accepted request: update the state and queue the result it causes
   function void note_item(note_req_type it);
      tone_rsp_type want;
      case (it.func)
         nst_pkg::FUNC_TICK: ms_tick();
         nst_pkg::FUNC_WRITE: begin
            freq_tab[it.slot]     = it.freq;
            dur_tab[it.slot]      = it.dur;
            slot_written[it.slot] = 1'b1;
         end
         nst_pkg::FUNC_PLAY: begin
            note_idx = '0;
            vol      = nst_pkg::VOL_PLAY;
         end
         nst_pkg::FUNC_VOL_UP: begin
            if (vol <= nst_pkg::VOL_UP_MAX) vol = vol + nst_pkg::VOL_STEP;
         end
         nst_pkg::FUNC_VOL_DOWN: begin
            if (vol >= nst_pkg::VOL_DOWN_MIN) vol = vol - nst_pkg::VOL_STEP;
         end
         default: ;
      endcase
      want.tone_on   = tone_en;
      want.tone_top  = top;
      want.duty      = 8'((int'(top) * int'(vol)) / PERCENT);
      want.volume    = vol;
      want.next_note = note_idx;
      want.song_done = (note_idx == song_len);
      expected_q.push_back(want);
   endfunction

   function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // accepted result: compare against the oldest expectation
   function void check_result(tone_rsp_type got);
      tone_rsp_type want;
      if (expected_q.size() == 0) begin
         $error("result transfer with no expectation waiting");
         errors++;
         return;
      end
      want = expected_q.pop_front();
      compared++;
      check_field("tone_on", want.tone_on, got.tone_on);
      check_field("tone_top", want.tone_top, got.tone_top);
      check_field("duty_compare", want.duty, got.duty);
      check_field("volume", want.volume, got.volume);
      check_field("next_note", want.next_note, got.next_note);
      check_field("song_done", want.song_done, got.song_done);
   endfunction
endclass

module testbench;
   import nst_pkg::*;

   // spare function codes that the block ignores
   localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;
   localparam int SETTLE_CYCLES = 40;
   localparam int TIMEOUT_NS    = 10_000_000;

   logic clock;
   logic reset;

   nst_req_if req_chan ();
   nst_rsp_if rsp_chan ();
   nst_csr_if csr_chan ();

   note_sequencer_tone_pwm_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   tone_scoreboard sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int held_cycles    = 0;
   int items_sent     = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // overall time limit
   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   // result side: check each transfer, stall at random or hold off when asked
   initial begin : result_sink
      tone_rsp_type got;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.tone_on   = rsp_chan.tone_on;
            got.tone_top  = rsp_chan.tone_top;
            got.duty      = rsp_chan.duty_compare;
            got.volume    = rsp_chan.volume;
            got.next_note = rsp_chan.next_note;
            got.song_done = rsp_chan.song_done;
            sb.check_result(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            held_cycles++;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // offer one request, with a random gap first, and wait for its transfer
   task automatic send_item(input note_req_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.func      <= it.func;
      req_chan.note_slot <= it.slot;
      req_chan.note_freq <= it.freq;
      req_chan.note_ms   <= it.dur;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_item(it);
      items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      sb.write_reg(idx, data);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every expected result is back, then let the block go quiet
   task automatic settle();
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic note_req_type item_of(logic [FUNC_W-1:0] func, int slot, int freq,
                                            int dur);
      note_req_type it;
      it.func = func;
      it.slot = SLOT_W'(slot);
      it.freq = FREQ_W'(freq);
      it.dur  = MS_W'(dur);
      return it;
   endfunction

   // frequencies spread over saturated, normal and silent notes
   function automatic logic [FREQ_W-1:0] pick_freq();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return FREQ_W'($urandom_range(1, 300));
         2:       return FREQ_W'($urandom_range(245, TONE_CLOCK_HZ_DEF));
         3:       return FREQ_W'($urandom_range(TONE_CLOCK_HZ_DEF + 1, 65535));
         default: return FREQ_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // random request; a tick that would fetch an unwritten slot becomes a write of it
   function automatic note_req_type make_item(int tick_pct, int play_pct, int dur_max);
      note_req_type it;
      int           roll;
      int           want_slot;
      it.slot = SLOT_W'($urandom_range(0, 63));
      it.freq = FREQ_W'($urandom_range(0, 65535));
      it.dur  = MS_W'($urandom_range(0, 65535));
      roll    = $urandom_range(0, 99);
      if (roll < tick_pct) begin
         it.func = FUNC_TICK;
      end else if (roll < tick_pct + play_pct) begin
         it.func = FUNC_PLAY;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               it.func = FUNC_WRITE;
               it.freq = pick_freq();
               it.dur  = MS_W'($urandom_range(0, dur_max));
            end
            4, 5:    it.func = FUNC_VOL_UP;
            6, 7, 8: it.func = FUNC_VOL_DOWN;
            default: it.func = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
         endcase
      end
      want_slot = sb.unwritten_fetch();
      if (it.func == FUNC_TICK && want_slot >= 0) begin
         it.func = FUNC_WRITE;
         it.slot = SLOT_W'(want_slot);
         it.freq = pick_freq();
         it.dur  = MS_W'($urandom_range(0, dur_max));
      end
      return it;
   endfunction

   // field extremes, every used function code, two spare codes and the short four-note song
   task automatic run_directed();
      settle();
      write_reg(CSR_SONG_LENGTH, 4);
      write_reg(CSR_SILENCE_MS, 0);
      send_item(item_of(FUNC_WRITE, 0, 65535, 65535));
      send_item(item_of(FUNC_WRITE, 63, 0, 0));
      // saturated period, shortest period, above the tone clock, rest
      send_item(item_of(FUNC_WRITE, 0, 1, 0));
      send_item(item_of(FUNC_WRITE, 1, TONE_CLOCK_HZ_DEF, 0));
      send_item(item_of(FUNC_WRITE, 2, TONE_CLOCK_HZ_DEF + 1, 1));
      send_item(item_of(FUNC_WRITE, 3, 0, 0));
      // volume floor before play, spare codes, play, volume ceiling
      send_item(item_of(FUNC_VOL_DOWN, 0, 0, 0));
      send_item(item_of(FUNC_SPARE_FIRST, 0, 0, 0));
      send_item(item_of(FUNC_SPARE_LAST, 63, 65535, 65535));
      send_item(item_of(FUNC_PLAY, 0, 0, 0));
      repeat (5) send_item(item_of(FUNC_VOL_UP, 0, 0, 0));
      // play through the song and past its end
      repeat (9) send_item(item_of(FUNC_TICK, 0, 0, 0));
      req_chan.valid <= 1'b0;
   endtask

   task automatic run_phase(input int len, input int silence, input int sidle,
                            input int rstall, input int hold, input int count,
                            input int tick_pct, input int play_pct, input int dur_max);
      note_req_type it;
      settle();
      write_reg(CSR_SONG_LENGTH, CSR_DATA_W'(len));
      write_reg(CSR_SILENCE_MS, CSR_DATA_W'(silence));
      send_idle_pct  = sidle;
      recv_stall_pct = rstall;
      hold_left      = hold;
      repeat (count) begin
         it = make_item(tick_pct, play_pct, dur_max);
         send_item(it);
      end
      req_chan.valid <= 1'b0;
   endtask

   // stimulus and final verdict
   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.func      <= FUNC_TICK;
      req_chan.note_slot <= '0;
      req_chan.note_freq <= '0;
      req_chan.note_ms   <= '0;
      csr_chan.valid     <= 1'b0;
      csr_chan.index     <= CSR_SONG_LENGTH;
      csr_chan.data      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      // short song, no idling
      run_phase(8, 2, 0, 0, 0, 60, 55, 5, 8);
      // full table with no gaps, sender idle
      run_phase(64, 0, 47, 0, 0, 220, 95, 0, 0);
      // empty song: index runs past the table and wraps, long result hold-off
      run_phase(0, 0, 0, 47, 400, 130, 90, 0, 0);
      // both sides idle
      run_phase(12, 3, 28, 28, 0, 50, 55, 5, 6);
      // receiver stalls with another hold-off
      run_phase(5, 1, 0, 47, 300, 50, 55, 5, 4);
      // longest silence gap last, since it holds the sequencer silent
      run_phase(20, 65535, 28, 28, 0, 40, 55, 5, 3);
      settle();

      $display("run: %0d requests sent, %0d results compared, %0d notes started",
               items_sent, sb.compared, sb.notes_started);
      $display("run: song lengths 0 to 64, gaps 0 to 65535 ms, %0d cycles of result hold-off",
               held_cycles);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
